### src/fcv_pkg.sv
// ---------------------------------------------------------------------------
// fcv_pkg
// shared types, constants and the fnv-1a prime fold for the frame validator
// ---------------------------------------------------------------------------
package fcv_pkg;

   localparam int unsigned TRAILER_BYTES = 8;
   localparam logic [31:0] HEADER_BYTES = 32'd20;
   localparam logic [31:0] MIN_FRAME_BYTES = 32'd28;
   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] FRAME_MAGIC = 32'h4352_5343;
   localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
   localparam logic [63:0] CELLS_LIMIT = 64'h0000_0000_2000_0000;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_CHECKSUM = 3'd2,
      ST_MAGIC    = 3'd3,
      ST_LENGTH   = 3'd4
   } status_type;

   // everything the checks need once the final byte is in
   typedef struct packed {
      logic [63:0] hash;
      logic [63:0] trailer;
      logic [31:0] total;
      logic [31:0] magic;
      logic [31:0] dim;
      logic [31:0] count;
      logic [63:0] gain;
   } frame_rec_type;

   // registered check flags and declared size
   typedef struct packed {
      logic        too_short;
      logic        hash_ok;
      logic        magic_ok;
      logic        saturated;
      logic [63:0] cells;
      logic [31:0] payload;
      logic [31:0] dim;
      logic [31:0] count;
      logic [63:0] gain;
   } judge_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] dim;
      logic [31:0] count;
      logic [63:0] gain;
   } result_type;

   // multiply by the fnv prime 2^40 + 0x1b3, modulo 2^64, as shifts and adds
   function automatic logic [63:0] fnv_mul(input logic [63:0] h);
      fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
   endfunction

endpackage

### src/fcv_accum.sv
// ---------------------------------------------------------------------------
// fcv_accum
// per-byte state: trailer delay line, fnv-1a hash, header capture, byte count
// ---------------------------------------------------------------------------
module fcv_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output logic                  frame_done,
   output fcv_pkg::frame_rec_type frame_rec
);

   logic [fcv_pkg::TRAILER_BYTES-1:0][7:0] window_ff, window_in, window_upd;
   logic [63:0] hash_ff, hash_in, hash_upd;
   logic [31:0] total_ff, total_in, total_upd;
   logic [31:0] magic_ff, magic_in, magic_upd;
   logic [31:0] dim_ff, dim_in, dim_upd;
   logic [31:0] count_ff, count_in, count_upd;
   logic [63:0] gain_ff, gain_in, gain_upd;
   logic [2:0]  gain_pos;
   logic        clear;

   always_comb begin
      gain_pos = 3'(total_ff[4:0] - 5'd12);

      // header capture by byte position
      magic_upd = magic_ff;
      dim_upd   = dim_ff;
      count_upd = count_ff;
      gain_upd  = gain_ff;
      if (total_ff < 32'd4) begin
         magic_upd[{total_ff[1:0], 3'b000} +: 8] = data_byte;
      end else if (total_ff < 32'd8) begin
         dim_upd[{total_ff[1:0], 3'b000} +: 8] = data_byte;
      end else if (total_ff < 32'd12) begin
         count_upd[{total_ff[1:0], 3'b000} +: 8] = data_byte;
      end else if (total_ff < fcv_pkg::HEADER_BYTES) begin
         gain_upd[{gain_pos, 3'b000} +: 8] = data_byte;
      end

      // the oldest byte leaves the delay line and folds into the hash
      if (total_ff >= 32'(fcv_pkg::TRAILER_BYTES)) begin
         hash_upd = fcv_pkg::fnv_mul(hash_ff ^ {56'd0, window_ff[0]});
      end else begin
         hash_upd = hash_ff;
      end

      for (int i = 0; i < fcv_pkg::TRAILER_BYTES - 1; i++) begin
         window_upd[i] = window_ff[i+1];
      end
      window_upd[fcv_pkg::TRAILER_BYTES-1] = data_byte;

      total_upd = (total_ff == fcv_pkg::TOTAL_MAX) ? total_ff : total_ff + 32'd1;

      clear = byte_accept && last_byte;
      if (clear) begin
         window_in = '0;
         hash_in   = fcv_pkg::FNV_BASIS;
         total_in  = '0;
         magic_in  = '0;
         dim_in    = '0;
         count_in  = '0;
         gain_in   = '0;
      end else if (byte_accept) begin
         window_in = window_upd;
         hash_in   = hash_upd;
         total_in  = total_upd;
         magic_in  = magic_upd;
         dim_in    = dim_upd;
         count_in  = count_upd;
         gain_in   = gain_upd;
      end else begin
         window_in = window_ff;
         hash_in   = hash_ff;
         total_in  = total_ff;
         magic_in  = magic_ff;
         dim_in    = dim_ff;
         count_in  = count_ff;
         gain_in   = gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         hash_ff   <= fcv_pkg::FNV_BASIS;
         total_ff  <= '0;
         magic_ff  <= '0;
         dim_ff    <= '0;
         count_ff  <= '0;
         gain_ff   <= '0;
      end else begin
         window_ff <= window_in;
         hash_ff   <= hash_in;
         total_ff  <= total_in;
         magic_ff  <= magic_in;
         dim_ff    <= dim_in;
         count_ff  <= count_in;
         gain_ff   <= gain_in;
      end
   end

   // newest byte ends up in the top byte of the trailer word
   assign frame_done        = clear;
   assign frame_rec.hash    = hash_upd;
   assign frame_rec.trailer = window_upd;
   assign frame_rec.total   = total_upd;
   assign frame_rec.magic   = magic_upd;
   assign frame_rec.dim     = dim_upd;
   assign frame_rec.count   = count_upd;
   assign frame_rec.gain    = gain_upd;

endmodule

### src/fcv_judge.sv
// ---------------------------------------------------------------------------
// fcv_judge
// two-stage frame check: capture and multiply, then status priority
// ---------------------------------------------------------------------------
module fcv_judge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   frame_done,
   input  fcv_pkg::frame_rec_type frame_rec,
   input  logic                   out_ready,
   output logic                   in_ready,
   output logic                   res_valid,
   output fcv_pkg::result_type    res
);

   logic                   rec_valid_ff, rec_valid_in;
   fcv_pkg::frame_rec_type rec_ff;
   logic                   jdg_valid_ff, jdg_valid_in;
   fcv_pkg::judge_type     jdg_ff, jdg_in;
   logic                   jdg_load, rec_load;
   logic                   size_ok;

   assign jdg_load = !jdg_valid_ff || out_ready;
   assign rec_load = !rec_valid_ff || jdg_load;
   assign in_ready = rec_load;

   always_comb begin
      rec_valid_in = rec_load ? frame_done : rec_valid_ff;
      jdg_valid_in = jdg_load ? rec_valid_ff : jdg_valid_ff;

      jdg_in.too_short = rec_ff.total < fcv_pkg::MIN_FRAME_BYTES;
      jdg_in.hash_ok   = rec_ff.trailer == rec_ff.hash;
      jdg_in.magic_ok  = rec_ff.magic == fcv_pkg::FRAME_MAGIC;
      jdg_in.saturated = rec_ff.total == fcv_pkg::TOTAL_MAX;
      jdg_in.cells     = {32'd0, rec_ff.count} * {32'd0, rec_ff.dim};
      jdg_in.payload   = rec_ff.total - fcv_pkg::MIN_FRAME_BYTES;
      jdg_in.dim       = rec_ff.dim;
      jdg_in.count     = rec_ff.count;
      jdg_in.gain      = rec_ff.gain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         jdg_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         jdg_valid_ff <= jdg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_load && frame_done) begin
         rec_ff <= frame_rec;
      end
      if (jdg_load && rec_valid_ff) begin
         jdg_ff <= jdg_in;
      end
   end

   // cells is checked to be at most 2^29 here, so the times-eight cannot wrap
   assign size_ok = (jdg_ff.cells <= fcv_pkg::CELLS_LIMIT)
                 && ({jdg_ff.cells[60:0], 3'b000} == {32'd0, jdg_ff.payload});

   always_comb begin
      if (jdg_ff.too_short) begin
         res.status = fcv_pkg::ST_SHORT;
      end else if (!jdg_ff.hash_ok) begin
         res.status = fcv_pkg::ST_CHECKSUM;
      end else if (!jdg_ff.magic_ok) begin
         res.status = fcv_pkg::ST_MAGIC;
      end else if (jdg_ff.saturated || !size_ok) begin
         res.status = fcv_pkg::ST_LENGTH;
      end else begin
         res.status = fcv_pkg::ST_OK;
      end

      if (res.status == fcv_pkg::ST_OK || res.status == fcv_pkg::ST_LENGTH) begin
         res.dim   = jdg_ff.dim;
         res.count = jdg_ff.count;
         res.gain  = jdg_ff.gain;
      end else begin
         res.dim   = '0;
         res.count = '0;
         res.gain  = '0;
      end
   end

   assign res_valid = jdg_valid_ff;

endmodule

### src/fnv_checked_frame_validator_top.sv
// ---------------------------------------------------------------------------
// fnv_checked_frame_validator_top
// streaming validator for checksummed saved-state frames
// ---------------------------------------------------------------------------
// Takes a frame one byte per transaction on the req side, tlast on the final
// byte, and returns one transaction on the rsp side per frame. The last eight
// bytes are the little-endian fnv-1a 64-bit hash of everything before them.
// Checks in priority order: at least 28 bytes (status 1), hash matches trailer
// (status 2), magic 0x43525343 at bytes 0..3 (status 3), and length equal to
// 20 + count*dim*8 + 8 (status 4); status 0 is a good frame. Header fields are
// zero in the result for status 1, 2 and 3. A new byte is taken every cycle
// unless the check pipeline is full and the result is not taken; the hash
// fold (xor and prime multiply feeding back on itself) is the loop that sets
// that rate. Results pass frame capture, size multiply, and status and output
// register. Back-to-back frames stream without gaps while results are taken.
// ---------------------------------------------------------------------------
module fnv_checked_frame_validator_top (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata    // [2:0] status, [34:3] dimension,
                                     // [66:35] vector_count, [130:67] gain_bits,
                                     // [135:131] zero
);

   logic                   byte_accept;
   logic                   frame_done;
   fcv_pkg::frame_rec_type frame_rec;
   logic                   out_ready;
   logic                   res_valid;
   fcv_pkg::result_type    res;

   logic                   rsp_valid_ff, rsp_valid_in;
   fcv_pkg::result_type    rsp_data_ff;

   assign byte_accept = req_tvalid && req_tready;

   // running per-frame state, cleared after the final byte
   fcv_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .frame_done  (frame_done),
      .frame_rec   (frame_rec)
   );

   // check pipeline; its first stage decides whether a byte can be taken
   fcv_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .frame_done (frame_done),
      .frame_rec  (frame_rec),
      .out_ready  (out_ready),
      .in_ready   (req_tready),
      .res_valid  (res_valid),
      .res        (res)
   );

   // output register, refilled as soon as the held result is taken
   assign out_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = out_ready ? res_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.gain, rsp_data_ff.count, rsp_data_ff.dim,
                        rsp_data_ff.status};

endmodule
